// File: design/xmbr_pkg.sv
`timescale 1ns / 1ps

package xmbr_pkg;

    // line control characters
    localparam logic [7:0] CH_SOH = 8'd1;
    localparam logic [7:0] CH_EOT = 8'd4;
    localparam logic [7:0] CH_ACK = 8'd6;
    localparam logic [7:0] CH_NAK = 8'd21;
    localparam logic [7:0] CH_CAN = 8'd24;
    localparam logic [7:0] CH_C   = 8'd67;
    localparam logic [7:0] CH_PAD = 8'd26;

    // crc-16 generator polynomial
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_MODE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 1'd1;

    // verdict fail reasons
    localparam logic [1:0] FAIL_NONE = 2'd0;
    localparam logic [1:0] FAIL_COMP = 2'd1;
    localparam logic [1:0] FAIL_SUM  = 2'd2;

    // session end status
    localparam logic [1:0] END_EOT  = 2'd0;
    localparam logic [1:0] END_CAN  = 2'd1;
    localparam logic [1:0] END_HAND = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HAND,
        PH_NUM,
        PH_COMP,
        PH_DATA,
        PH_CHI,
        PH_CLO,
        PH_GAP
    } t_phase;

    typedef struct packed {
        logic       crc_mode;
        logic [3:0] max_attempts;
    } t_cfg;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       keep_byte;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       verdict_valid;
        logic       packet_good;
        logic [1:0] fail_reason;
        logic [7:0] block_number;
        logic       session_end;
        logic [1:0] end_status;
    } t_result;

endpackage

// File: design/xmbr_if.sv
`timescale 1ns / 1ps

// line byte channel
interface xmbr_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

// result channel
interface xmbr_out_if;
    logic       valid;
    logic       ready;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       keep_byte;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       verdict_valid;
    logic       packet_good;
    logic [1:0] fail_reason;
    logic [7:0] block_number;
    logic       session_end;
    logic [1:0] end_status;

    modport source (
        output valid, output data_valid, output data_byte, output keep_byte,
        output tx_valid, output tx_byte, output verdict_valid, output packet_good,
        output fail_reason, output block_number, output session_end,
        output end_status, input ready
    );
    modport sink (
        input valid, input data_valid, input data_byte, input keep_byte,
        input tx_valid, input tx_byte, input verdict_valid, input packet_good,
        input fail_reason, input block_number, input session_end,
        input end_status, output ready
    );
endinterface

// configuration write channel
interface xmbr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [xmbr_pkg::CFG_IDX_W-1:0]   index;
    logic [7:0]                       data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/xmbr_cfg_regs.sv
`timescale 1ns / 1ps

module xmbr_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    xmbr_cfg_if.sink         i_cfg,
    output xmbr_pkg::t_cfg   o_cfg
);

    xmbr_pkg::t_cfg r_cfg;

    // writes are always taken
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crc_mode     <= 1'b0;
            r_cfg.max_attempts <= 4'd6;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                xmbr_pkg::CFG_CRC_MODE:     r_cfg.crc_mode     <= i_cfg.data[0];
                xmbr_pkg::CFG_MAX_ATTEMPTS: r_cfg.max_attempts <= i_cfg.data[3:0];
                default: ;
            endcase
        end
    end

endmodule

// File: design/xmbr_crc_step.sv
`timescale 1ns / 1ps

module xmbr_crc_step (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    // one byte of crc-16, msb first, eight shifts unrolled
    always_comb begin
        logic [15:0] v_crc;
        v_crc = i_crc ^ {i_byte, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (v_crc[15]) begin
                v_crc = {v_crc[14:0], 1'b0} ^ xmbr_pkg::CRC_POLY;
            end else begin
                v_crc = {v_crc[14:0], 1'b0};
            end
        end
        o_crc = v_crc;
    end

endmodule

// File: design/xmbr_fsm.sv
`timescale 1ns / 1ps

module xmbr_fsm #(
    parameter int BLOCK_BYTES = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_mode,
    input  logic [7:0]          i_byte,
    input  xmbr_pkg::t_cfg      i_cfg,
    output logic                o_res_valid,
    output xmbr_pkg::t_result   o_res
);

    localparam int IDX_W = $clog2(BLOCK_BYTES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BLOCK_BYTES - 1);

    xmbr_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_attempt, n_attempt;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_blk_num, n_blk_num;
    logic [7:0]       r_comp, n_comp;
    logic [7:0]       r_sum, n_sum;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_crc_hi, n_crc_hi;
    logic [15:0]      crc_next;
    logic             comp_bad;
    logic             check_bad;
    logic [7:0]       request;

    xmbr_crc_step u_crc (
        .i_crc  (r_crc),
        .i_byte (i_byte),
        .o_crc  (crc_next)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= xmbr_pkg::PH_IDLE;
            r_attempt <= '0;
            r_idx     <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_attempt <= n_attempt;
            r_idx     <= n_idx;
        end
    end

    // block header and check accumulators
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_blk_num <= n_blk_num;
            r_comp    <= n_comp;
            r_sum     <= n_sum;
            r_crc     <= n_crc;
            r_crc_hi  <= n_crc_hi;
        end
    end

    // block verdict terms
    assign comp_bad  = (~r_blk_num) != r_comp;
    assign check_bad = i_cfg.crc_mode ? ({r_crc_hi, i_byte} != r_crc) : (i_byte != r_sum);
    assign request   = i_cfg.crc_mode ? xmbr_pkg::CH_C : xmbr_pkg::CH_NAK;

    // next state and result
    always_comb begin
        n_phase     = r_phase;
        n_attempt   = r_attempt;
        n_idx       = r_idx;
        n_blk_num   = r_blk_num;
        n_comp      = r_comp;
        n_sum       = r_sum;
        n_crc       = r_crc;
        n_crc_hi    = r_crc_hi;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (!i_mode) begin
            n_phase        = xmbr_pkg::PH_HAND;
            n_attempt      = 4'd1;
            o_res_valid    = 1'b1;
            o_res.tx_valid = 1'b1;
            o_res.tx_byte  = request;
        end else begin
            unique case (r_phase) inside
                xmbr_pkg::PH_IDLE: ;
                xmbr_pkg::PH_HAND: begin
                    if (i_byte == xmbr_pkg::CH_SOH) begin
                        n_phase = xmbr_pkg::PH_NUM;
                    end else if (r_attempt < i_cfg.max_attempts) begin
                        n_attempt      = r_attempt + 4'd1;
                        o_res_valid    = 1'b1;
                        o_res.tx_valid = 1'b1;
                        o_res.tx_byte  = request;
                    end else begin
                        n_phase           = xmbr_pkg::PH_IDLE;
                        o_res_valid       = 1'b1;
                        o_res.session_end = 1'b1;
                        o_res.end_status  = xmbr_pkg::END_HAND;
                    end
                end
                xmbr_pkg::PH_NUM: begin
                    n_blk_num = i_byte;
                    n_phase   = xmbr_pkg::PH_COMP;
                end
                xmbr_pkg::PH_COMP: begin
                    n_comp  = i_byte;
                    n_idx   = '0;
                    n_sum   = '0;
                    n_crc   = '0;
                    n_phase = xmbr_pkg::PH_DATA;
                end
                xmbr_pkg::PH_DATA: begin
                    n_sum            = r_sum + i_byte;
                    n_crc            = crc_next;
                    o_res_valid      = 1'b1;
                    o_res.data_valid = 1'b1;
                    o_res.data_byte  = i_byte;
                    o_res.keep_byte  = i_byte != xmbr_pkg::CH_PAD;
                    if (r_idx == IDX_LAST) begin
                        n_idx   = '0;
                        n_phase = xmbr_pkg::PH_CHI;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                xmbr_pkg::PH_CHI, xmbr_pkg::PH_CLO: begin
                    if (r_phase == xmbr_pkg::PH_CHI && i_cfg.crc_mode) begin
                        n_crc_hi = i_byte;
                        n_phase  = xmbr_pkg::PH_CLO;
                    end else begin
                        n_phase             = xmbr_pkg::PH_GAP;
                        o_res_valid         = 1'b1;
                        o_res.tx_valid      = 1'b1;
                        o_res.verdict_valid = 1'b1;
                        o_res.block_number  = r_blk_num;
                        if (comp_bad) begin
                            o_res.tx_byte     = xmbr_pkg::CH_NAK;
                            o_res.fail_reason = xmbr_pkg::FAIL_COMP;
                        end else if (check_bad) begin
                            o_res.tx_byte     = xmbr_pkg::CH_NAK;
                            o_res.fail_reason = xmbr_pkg::FAIL_SUM;
                        end else begin
                            o_res.tx_byte     = xmbr_pkg::CH_ACK;
                            o_res.packet_good = 1'b1;
                            o_res.fail_reason = xmbr_pkg::FAIL_NONE;
                        end
                    end
                end
                xmbr_pkg::PH_GAP: begin
                    if (i_byte == xmbr_pkg::CH_SOH) begin
                        n_phase = xmbr_pkg::PH_NUM;
                    end else if (i_byte == xmbr_pkg::CH_EOT) begin
                        n_phase           = xmbr_pkg::PH_IDLE;
                        o_res_valid       = 1'b1;
                        o_res.tx_valid    = 1'b1;
                        o_res.tx_byte     = xmbr_pkg::CH_ACK;
                        o_res.session_end = 1'b1;
                        o_res.end_status  = xmbr_pkg::END_EOT;
                    end else if (i_byte == xmbr_pkg::CH_CAN) begin
                        n_phase           = xmbr_pkg::PH_IDLE;
                        o_res_valid       = 1'b1;
                        o_res.session_end = 1'b1;
                        o_res.end_status  = xmbr_pkg::END_CAN;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: design/xmodem_block_receiver.sv
`timescale 1ns / 1ps

// XMODEM block receiver, one line byte per beat. An input beat is captured in an
// input register, judged in one pass of logic (phase decode, 8-bit sum and an
// unrolled crc-16 byte step) and its result, if any, is loaded into an output
// register, so a result is offered only after its beat has passed the input
// register and then the output register. One input beat is taken every cycle
// while the result side keeps up; a held result stalls the input only once the
// input register is also full. Beats that cause no result (header bytes, check
// high byte, stray bytes) produce no output beat. Configuration writes are taken
// in every cycle and should only be issued while no item is in flight.
module xmodem_block_receiver #(
    parameter int BLOCK_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    xmbr_in_if.sink     i_rx,
    xmbr_out_if.source  o_res,
    xmbr_cfg_if.sink    i_cfg
);

    xmbr_pkg::t_cfg    cfg;
    xmbr_pkg::t_result res;
    logic              res_valid;
    logic              advance;
    logic              r_in_valid;
    logic              r_in_mode;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    xmbr_pkg::t_result r_out;

    xmbr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    xmbr_fsm #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_mode      (r_in_mode),
        .i_byte      (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // held beat moves on when the result register can take it
    assign advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_mode <= i_rx.mode;
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    // output beat
    assign o_res.valid         = r_out_valid;
    assign o_res.data_valid    = r_out.data_valid;
    assign o_res.data_byte     = r_out.data_byte;
    assign o_res.keep_byte     = r_out.keep_byte;
    assign o_res.tx_valid      = r_out.tx_valid;
    assign o_res.tx_byte       = r_out.tx_byte;
    assign o_res.verdict_valid = r_out.verdict_valid;
    assign o_res.packet_good   = r_out.packet_good;
    assign o_res.fail_reason   = r_out.fail_reason;
    assign o_res.block_number  = r_out.block_number;
    assign o_res.session_end   = r_out.session_end;
    assign o_res.end_status    = r_out.end_status;

endmodule

// File: test/xmbr_tb_pkg.sv
`timescale 1ns / 1ps

package xmbr_tb_pkg;

    // one byte through the crc-16 shift register, high bit first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ xmbr_pkg::CRC_POLY) : (c << 1);
        return c;
    endfunction

endpackage

// File: test/xmbr_checker.sv
`timescale 1ns / 1ps

module xmbr_checker
    import xmbr_pkg::*;
    import xmbr_tb_pkg::*;
#(
    parameter int BLOCK_BYTES = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    xmbr_in_if   i_rx,
    xmbr_out_if  i_res,
    xmbr_cfg_if  i_cfg,
    input  logic i_end_check,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_blocks_good,
    output int   o_blocks_bad,
    output int   o_sessions
);

    // receiver state as the checker sees it
    t_cfg        cfg_q;
    t_phase      phase_q;
    logic [3:0]  attempts_q;
    logic [7:0]  blk_num_q;
    logic [7:0]  blk_comp_q;
    logic [7:0]  sum_q;
    logic [15:0] crc_q;
    logic [7:0]  crc_hi_q;
    int unsigned byte_cnt_q;

    t_result pending_results[$];
    int      fails;
    int      n_good;
    int      n_bad;
    int      n_ends;
    bit      end_done;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fails++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // verdict on a complete block, complement first, then sum or crc
    function automatic t_result judge_block(input logic [7:0] lo);
        t_result    v;
        logic [1:0] why;
        v = '0;
        if (8'(8'hFF - blk_num_q) != blk_comp_q)
            why = FAIL_COMP;
        else if (cfg_q.crc_mode ? (crc_q != {crc_hi_q, lo}) : (sum_q != lo))
            why = FAIL_SUM;
        else
            why = FAIL_NONE;
        v.tx_valid      = 1'b1;
        v.tx_byte       = (why == FAIL_NONE) ? CH_ACK : CH_NAK;
        v.verdict_valid = 1'b1;
        v.packet_good   = (why == FAIL_NONE);
        v.fail_reason   = why;
        v.block_number  = blk_num_q;
        return v;
    endfunction

    // advance the receiver by one line beat and queue what it answers
    task automatic predict_beat(input logic mode_in, input logic [7:0] b);
        t_result r;
        bit      hit;
        r   = '0;
        hit = 1'b0;
        if (mode_in == 1'b0) begin
            phase_q    = PH_HAND;
            attempts_q = 4'd1;
            r.tx_valid = 1'b1;
            r.tx_byte  = cfg_q.crc_mode ? CH_C : CH_NAK;
            hit        = 1'b1;
        end else begin
            case (phase_q)
                PH_HAND: begin
                    if (b == CH_SOH) begin
                        phase_q = PH_NUM;
                    end else if (attempts_q < cfg_q.max_attempts) begin
                        attempts_q++;
                        r.tx_valid = 1'b1;
                        r.tx_byte  = cfg_q.crc_mode ? CH_C : CH_NAK;
                        hit        = 1'b1;
                    end else begin
                        phase_q       = PH_IDLE;
                        r.session_end = 1'b1;
                        r.end_status  = END_HAND;
                        hit           = 1'b1;
                    end
                end
                PH_NUM: begin
                    blk_num_q = b;
                    phase_q   = PH_COMP;
                end
                PH_COMP: begin
                    blk_comp_q = b;
                    byte_cnt_q = 0;
                    sum_q      = '0;
                    crc_q      = '0;
                    phase_q    = PH_DATA;
                end
                PH_DATA: begin
                    sum_q       = sum_q + b;
                    crc_q       = crc16_byte(crc_q, b);
                    r.data_valid = 1'b1;
                    r.data_byte  = b;
                    r.keep_byte  = (b != CH_PAD);
                    hit          = 1'b1;
                    byte_cnt_q++;
                    if (byte_cnt_q >= BLOCK_BYTES) begin
                        byte_cnt_q = 0;
                        phase_q    = PH_CHI;
                    end
                end
                PH_CHI: begin
                    if (cfg_q.crc_mode) begin
                        crc_hi_q = b;
                        phase_q  = PH_CLO;
                    end else begin
                        r       = judge_block(b);
                        hit     = 1'b1;
                        phase_q = PH_GAP;
                    end
                end
                PH_CLO: begin
                    r       = judge_block(b);
                    hit     = 1'b1;
                    phase_q = PH_GAP;
                end
                PH_GAP: begin
                    if (b == CH_SOH) begin
                        phase_q = PH_NUM;
                    end else if (b == CH_EOT) begin
                        phase_q       = PH_IDLE;
                        r.tx_valid    = 1'b1;
                        r.tx_byte     = CH_ACK;
                        r.session_end = 1'b1;
                        r.end_status  = END_EOT;
                        hit           = 1'b1;
                    end else if (b == CH_CAN) begin
                        phase_q       = PH_IDLE;
                        r.session_end = 1'b1;
                        r.end_status  = END_CAN;
                        hit           = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (hit)
            pending_results.push_back(r);
    endtask

    // compare one result beat with the oldest expectation
    task automatic compare_result();
        t_result want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected, tx=%0h data=%0h",
                                      i_res.tx_byte, i_res.data_byte));
            return;
        end
        want = pending_results.pop_front();
        check_field("data_valid", 8'(i_res.data_valid), 8'(want.data_valid));
        check_field("data_byte", i_res.data_byte, want.data_byte);
        check_field("keep_byte", 8'(i_res.keep_byte), 8'(want.keep_byte));
        check_field("tx_valid", 8'(i_res.tx_valid), 8'(want.tx_valid));
        check_field("tx_byte", i_res.tx_byte, want.tx_byte);
        check_field("verdict_valid", 8'(i_res.verdict_valid), 8'(want.verdict_valid));
        check_field("packet_good", 8'(i_res.packet_good), 8'(want.packet_good));
        check_field("fail_reason", 8'(i_res.fail_reason), 8'(want.fail_reason));
        check_field("block_number", i_res.block_number, want.block_number);
        check_field("session_end", 8'(i_res.session_end), 8'(want.session_end));
        check_field("end_status", 8'(i_res.end_status), 8'(want.end_status));
        if (i_res.verdict_valid === 1'b1) begin
            if (i_res.packet_good === 1'b1)
                n_good++;
            else
                n_bad++;
        end
        if (i_res.session_end === 1'b1)
            n_ends++;
    endtask

    // watch config, line and result channels every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_q.crc_mode     = 1'b0;
            cfg_q.max_attempts = 4'd6;
            phase_q    = PH_IDLE;
            attempts_q = '0;
            blk_num_q  = '0;
            blk_comp_q = '0;
            sum_q      = '0;
            crc_q      = '0;
            crc_hi_q   = '0;
            byte_cnt_q = 0;
            pending_results.delete();
            end_done   = 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_CRC_MODE)
                    cfg_q.crc_mode = i_cfg.data[0];
                else if (i_cfg.index == CFG_MAX_ATTEMPTS)
                    cfg_q.max_attempts = i_cfg.data[3:0];
            end
            if (i_rx.valid && i_rx.ready)
                predict_beat(i_rx.mode, i_rx.rx_byte);
            if (i_res.valid && i_res.ready)
                compare_result();
            if (i_end_check && !end_done) begin
                end_done = 1'b1;
                if (pending_results.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived",
                                              pending_results.size()));
            end
        end
        o_pending     <= pending_results.size();
        o_fail_count  <= fails;
        o_blocks_good <= n_good;
        o_blocks_bad  <= n_bad;
        o_sessions    <= n_ends;
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import xmbr_pkg::*;
    import xmbr_tb_pkg::*;

    localparam int BLOCK_BYTES   = 128;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_BEATS  = 750;

    typedef enum int {RDY_FULL, RDY_HALF, RDY_SPARSE, RDY_BLOCKED} t_ready_mode;
    typedef enum int {BLK_GOOD, BLK_BAD_COMP, BLK_BAD_CHECK, BLK_BAD_BOTH, BLK_ABORT} t_blk_kind;

    logic i_clk;
    logic i_rst_n;
    logic end_check;

    xmbr_in_if  rx ();
    xmbr_out_if res ();
    xmbr_cfg_if cfg ();

    int fail_count;
    int pending;
    int blocks_good;
    int blocks_bad;
    int sessions;

    int          line_beats;
    int          burst_left;
    logic        cur_crc;
    logic [3:0]  cur_att;
    t_ready_mode ready_mode;
    int          ready_left;

    xmodem_block_receiver #(.BLOCK_BYTES(BLOCK_BYTES)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    xmbr_checker #(.BLOCK_BYTES(BLOCK_BYTES)) chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx          (rx),
        .i_res         (res),
        .i_cfg         (cfg),
        .i_end_check   (end_check),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_blocks_good (blocks_good),
        .o_blocks_bad  (blocks_bad),
        .o_sessions    (sessions)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side stalls in segments of varying pattern
    initial begin
        res.ready <= 1'b0;
        ready_mode = RDY_FULL;
        ready_left = 0;
        forever begin
            @(posedge i_clk);
            if (ready_left == 0) begin
                ready_mode = t_ready_mode'($urandom_range(0, 3));
                ready_left = $urandom_range(16, 96);
            end else
                ready_left--;
            case (ready_mode)
                RDY_FULL:   res.ready <= 1'b1;
                RDY_HALF:   res.ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE: res.ready <= ($urandom_range(0, 3) == 0);
                default:    res.ready <= (ready_left < 4);
            endcase
        end
    end

    // one line beat, sent in bursts with random gaps between them
    task automatic send_beat(input logic m, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                rx.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        rx.valid   <= 1'b1;
        rx.mode    <= m;
        rx.rx_byte <= b;
        do @(posedge i_clk); while (rx.ready !== 1'b1);
        line_beats++;
    endtask

    // stop sending and let every expected result come out
    task automatic wait_drained();
        rx.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        wait_drained();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge i_clk); while (cfg.ready !== 1'b1);
        cfg.valid <= 1'b0;
    endtask

    // unused upper data bits are filled at random
    task automatic set_config(input logic crc, input logic [3:0] att);
        cfg_write(CFG_CRC_MODE, {7'($urandom), crc});
        cfg_write(CFG_MAX_ATTEMPTS, {4'($urandom), att});
        cur_crc = crc;
        cur_att = att;
    endtask

    // bytes that are not SOH, EOT or CAN, skipped between blocks
    task automatic send_stray_bytes(input int count);
        logic [7:0] b;
        repeat (count) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_SOH || b == CH_EOT || b == CH_CAN)
                b = 8'h55;
            send_beat(1'b1, b);
        end
    endtask

    // stimulus and verdict
    initial begin
        int          sess;
        int          rand_base;
        int          eff;
        int          n_noise;
        int          n_blk;
        int          abort_at;
        int          pad_from;
        int          k;
        bit          hs_fail;
        bit          aborted;
        t_blk_kind   kind;
        logic [7:0]  bnum;
        logic [7:0]  bcomp;
        logic [7:0]  b;
        logic [7:0]  sum;
        logic [7:0]  chk_hi;
        logic [7:0]  chk_lo;
        logic [15:0] crc;

        rx.valid   <= 1'b0;
        rx.mode    <= 1'b0;
        rx.rx_byte <= 8'h00;
        cfg.valid  <= 1'b0;
        cfg.index  <= CFG_CRC_MODE;
        cfg.data   <= 8'h00;
        end_check  <= 1'b0;
        i_rst_n    <= 1'b0;
        cur_crc    = 1'b0;
        cur_att    = 4'd6;
        burst_left = 0;
        line_beats = 0;
        aborted    = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: checksum mode, six attempts
        set_config(1'b0, 4'd6);
        // bytes while idle are dropped
        send_beat(1'b1, 8'h00);
        send_beat(1'b1, 8'hFF);
        send_beat(1'b1, CH_SOH);
        // handshake: EOT and CAN count as failed attempts like any other byte
        send_beat(1'b0, 8'hFF);
        send_beat(1'b1, CH_EOT);
        send_beat(1'b1, CH_CAN);
        send_beat(1'b1, 8'hFF);
        send_beat(1'b1, 8'h00);
        // start again mid handshake, then run the attempts out
        send_beat(1'b0, 8'h00);
        send_beat(1'b1, 8'h80);
        send_beat(1'b1, 8'h7F);
        send_beat(1'b1, CH_ACK);
        send_beat(1'b1, CH_NAK);
        send_beat(1'b1, CH_C);
        send_beat(1'b1, 8'h55);
        send_beat(1'b1, CH_PAD);
        // crc mode, zero attempts acts as a single one
        set_config(1'b1, 4'd0);
        send_beat(1'b0, 8'h5A);
        send_beat(1'b1, 8'h02);
        // restart after a complete block header, before its data
        send_beat(1'b0, 8'hA5);
        send_beat(1'b1, CH_SOH);
        send_beat(1'b1, 8'h00);
        send_beat(1'b1, 8'hFF);
        send_beat(1'b0, 8'h00);
        send_beat(1'b1, CH_CAN);

        // random sessions, new settings before each one
        sess      = 0;
        rand_base = line_beats;
        while ((line_beats - rand_base) < RANDOM_BEATS || sess < 4) begin
            case (sess)
                0:       set_config(1'b0, 4'd15);
                1:       set_config(1'b1, 4'd1);
                2:       set_config(1'b1, 4'd15);
                3:       set_config(1'b0, 4'd0);
                default: set_config(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            endcase
            eff = (cur_att == 0) ? 1 : cur_att;

            // line noise before the start, dropped unless a session was left open
            k = $urandom_range(0, 2);
            repeat (k) send_beat(1'b1, 8'($urandom_range(0, 255)));
            if (!aborted)
                line_beats -= k;

            // handshake with a few rejected bytes, sometimes all of them
            send_beat(1'b0, 8'($urandom_range(0, 255)));
            hs_fail = ($urandom_range(0, 9) == 0);
            n_noise = hs_fail ? eff : $urandom_range(0, (eff > 3) ? 3 : eff - 1);
            repeat (n_noise) begin
                case ($urandom_range(0, 5))
                    0:       b = CH_EOT;
                    1:       b = CH_CAN;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                if (b == CH_SOH)
                    b = 8'hFF;
                send_beat(1'b1, b);
            end
            aborted = 1'b0;

            if (!hs_fail) begin
                send_beat(1'b1, CH_SOH);
                n_blk = $urandom_range(1, 2);
                for (int blk = 0; blk < n_blk && !aborted; blk++) begin
                    if (blk > 0) begin
                        // stop adding blocks once the beat budget is spent
                        if ((line_beats - rand_base) >= RANDOM_BEATS)
                            break;
                        send_stray_bytes($urandom_range(0, 2));
                        send_beat(1'b1, CH_SOH);
                    end
                    case ($urandom_range(0, 11))
                        0:       kind = BLK_BAD_COMP;
                        1:       kind = BLK_BAD_CHECK;
                        2:       kind = BLK_BAD_BOTH;
                        3:       kind = BLK_ABORT;
                        default: kind = BLK_GOOD;
                    endcase
                    bnum  = 8'($urandom_range(0, 255));
                    bcomp = 8'(8'hFF - bnum);
                    if (kind == BLK_BAD_COMP || kind == BLK_BAD_BOTH)
                        bcomp ^= 8'(1 << $urandom_range(0, 7));
                    abort_at = (kind == BLK_ABORT) ? $urandom_range(0, BLOCK_BYTES - 1)
                                                   : BLOCK_BYTES;
                    // some blocks end in a run of padding
                    pad_from = ($urandom_range(0, 3) == 0) ? $urandom_range(0, BLOCK_BYTES)
                                                           : BLOCK_BYTES;
                    send_beat(1'b1, bnum);
                    send_beat(1'b1, bcomp);
                    sum = '0;
                    crc = '0;
                    for (int i = 0; i < BLOCK_BYTES && !aborted; i++) begin
                        if (i == abort_at) begin
                            send_beat(1'b0, 8'($urandom_range(0, 255)));
                            aborted = 1'b1;
                        end else begin
                            b   = (i >= pad_from) ? CH_PAD : 8'($urandom_range(0, 255));
                            sum = sum + b;
                            crc = crc16_byte(crc, b);
                            send_beat(1'b1, b);
                        end
                    end
                    if (!aborted) begin
                        chk_hi = crc[15:8];
                        chk_lo = cur_crc ? crc[7:0] : sum;
                        if (kind == BLK_BAD_CHECK || kind == BLK_BAD_BOTH) begin
                            if (cur_crc && $urandom_range(0, 1))
                                chk_hi ^= 8'(1 << $urandom_range(0, 7));
                            else
                                chk_lo ^= 8'(1 << $urandom_range(0, 7));
                        end
                        if (cur_crc)
                            send_beat(1'b1, chk_hi);
                        send_beat(1'b1, chk_lo);
                    end
                end
                // close the session normally or cancel it
                if (!aborted) begin
                    send_stray_bytes($urandom_range(0, 1));
                    send_beat(1'b1, ($urandom_range(0, 3) == 0) ? CH_CAN : CH_EOT);
                end
            end
            sess++;
        end

        wait_drained();
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("covered %0d line beats over %0d random sessions, checksum and crc modes",
                 line_beats, sess);
        $display("%0d blocks committed, %0d rejected, %0d sessions closed, %0d mismatches",
                 blocks_good, blocks_bad, sessions, fail_count);
        if (fail_count == 0)
            $display("PASS xmodem_block_receiver");
        else
            $display("FAIL xmodem_block_receiver");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("FAIL xmodem_block_receiver");
        $finish;
    end

endmodule

// File: xmodem_block_receiver.f
design/xmbr_pkg.sv
design/xmbr_if.sv
design/xmbr_cfg_regs.sv
design/xmbr_crc_step.sv
design/xmbr_fsm.sv
design/xmodem_block_receiver.sv
test/xmbr_tb_pkg.sv
test/xmbr_checker.sv
test/tb_top.sv
